/* hw/rtl/rdvl_pkg.sv */
// rdvl_pkg: shared types and constants of the record deframer.
// Used by rdvl_front, rdvl_queue, rdvl_back and the top level.
// No dependencies.
`default_nettype none
package rdvl_pkg;

	localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;
	localparam int unsigned QUEUE_DEPTH          = 4;
	localparam int unsigned LEN_W                = 28;

	localparam logic [7:0] START_MARKER_RST  = 8'd2;
	localparam logic [7:0] END_MARKER_RST    = 8'd3;
	localparam logic [7:0] MAX_TYPE_RST      = 8'd6;
	localparam logic [7:0] FALLBACK_TYPE_RST = 8'd5;

	localparam logic [1:0] REG_START_MARKER  = 2'd0;
	localparam logic [1:0] REG_END_MARKER    = 2'd1;
	localparam logic [1:0] REG_MAX_TYPE      = 2'd2;
	localparam logic [1:0] REG_FALLBACK_TYPE = 2'd3;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_END   = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef struct packed {
		logic [7:0] start_marker;
		logic [7:0] end_marker;
		logic [7:0] max_type;
		logic [7:0] fallback_type;
	} cfg_t;

	typedef struct packed {
		logic             kind;
		logic [7:0]       data;
		logic [7:0]       rtype;
		logic [7:0]       reply;
		logic [7:0]       flags;
		logic [LEN_W-1:0] length;
		logic [1:0]       status;
	} entry_t;

endpackage
`default_nettype wire

/* hw/rtl/record_deframer_varint_length.sv */
// record_deframer_varint_length: top level; configuration registers,
// parser front, entry queue and output stage.
// Depends on rdvl_pkg, rdvl_front, rdvl_queue, rdvl_back.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_stall    | rx_byte
//  out     | out_valid / out_stall  | kind data_byte record_type mapped_type
//          |                        | reply_line flag_bits payload_length
//          |                        | status last
//  cfg     | cfg_we                 | cfg_index cfg_data
//
// One input byte per cycle sustained while the queue is not full; each result
// goes into a queue slot, then the output register. The four-entry queue
// decouples the sides: in_stall rises only when it is full. Reset clears
// the parser state, the queue pointers and the registers to their defaults.
`default_nettype none
module record_deframer_varint_length #(
	parameter int unsigned MAX_LENGTH_BYTES = rdvl_pkg::MAX_LENGTH_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [7:0]       data_byte,
	output logic [7:0]       record_type,
	output logic [7:0]       mapped_type,
	output logic [7:0]       reply_line,
	output logic [7:0]       flag_bits,
	output logic [27:0]      payload_length,
	output logic [1:0]       status,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	rdvl_pkg::cfg_t   cfg_q;
	rdvl_pkg::entry_t push_entry;
	rdvl_pkg::entry_t head;
	logic             push;
	logic             pop;
	logic             full;
	logic             not_empty;
	logic             beat;

	assign in_stall = full;
	assign beat     = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker  <= rdvl_pkg::START_MARKER_RST;
			cfg_q.end_marker    <= rdvl_pkg::END_MARKER_RST;
			cfg_q.max_type      <= rdvl_pkg::MAX_TYPE_RST;
			cfg_q.fallback_type <= rdvl_pkg::FALLBACK_TYPE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rdvl_pkg::REG_START_MARKER:  cfg_q.start_marker  <= cfg_data;
				rdvl_pkg::REG_END_MARKER:    cfg_q.end_marker    <= cfg_data;
				rdvl_pkg::REG_MAX_TYPE:      cfg_q.max_type      <= cfg_data;
				rdvl_pkg::REG_FALLBACK_TYPE: cfg_q.fallback_type <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	rdvl_front #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (beat),
		.rx_byte    (rx_byte),
		.cfg        (cfg_q),
		.push       (push),
		.push_entry (push_entry)
	);

	rdvl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.not_empty  (not_empty),
		.head       (head)
	);

	rdvl_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_valid        (not_empty),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.data_byte      (data_byte),
		.record_type    (record_type),
		.mapped_type    (mapped_type),
		.reply_line     (reply_line),
		.flag_bits      (flag_bits),
		.payload_length (payload_length),
		.status         (status),
		.last           (last)
	);

endmodule
`default_nettype wire

/* hw/rtl/rdvl_front.sv */
// rdvl_front: byte parser; hunts for records, gathers header and length,
// and pushes data and status entries into the queue.
// Depends on rdvl_pkg.
`default_nettype none
module rdvl_front #(
	parameter int unsigned MAX_LENGTH_BYTES = rdvl_pkg::MAX_LENGTH_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          beat,
	input  wire logic [7:0]    rx_byte,
	input  wire rdvl_pkg::cfg_t cfg,
	output logic               push,
	output rdvl_pkg::entry_t   push_entry
);

	typedef enum logic [2:0] {
		HUNT, TYPE_B, REPLY_B, UNUSED_B, FLAGS_B, LENGTH_B, PAYLOAD_B, END_B
	} phase_t;

	phase_t                       phase_q;
	logic [7:0]                   type_q;
	logic [7:0]                   reply_q;
	logic [7:0]                   flags_q;
	logic [rdvl_pkg::LEN_W-1:0]   accum_q;
	logic [2:0]                   idx_q;
	logic [rdvl_pkg::LEN_W-1:0]   left_q;

	logic [5:0]                   shamt;
	logic [63:0]                  part_wide;
	logic [rdvl_pkg::LEN_W-1:0]   accum_nx;
	logic [2:0]                   idx_nx;
	logic                         too_long;
	logic [rdvl_pkg::LEN_W-1:0]   left_nx;

	assign shamt     = {idx_q, 3'b000} - {3'b000, idx_q};
	assign part_wide = 64'(rx_byte[6:0]) << shamt;
	assign accum_nx  = accum_q + part_wide[rdvl_pkg::LEN_W-1:0];
	assign idx_nx    = idx_q + 3'd1;
	assign too_long  = (idx_nx == 3'd0) || ({1'b0, idx_nx} >= 4'(MAX_LENGTH_BYTES));
	assign left_nx   = left_q - rdvl_pkg::LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HUNT;
			type_q  <= '0;
			reply_q <= '0;
			flags_q <= '0;
			accum_q <= '0;
			idx_q   <= '0;
			left_q  <= '0;
		end else if (beat) begin
			unique case (phase_q)
				HUNT: begin
					if (rx_byte == cfg.start_marker) phase_q <= TYPE_B;
				end
				TYPE_B: begin
					type_q  <= rx_byte;
					phase_q <= REPLY_B;
				end
				REPLY_B: begin
					reply_q <= rx_byte;
					phase_q <= UNUSED_B;
				end
				UNUSED_B: phase_q <= FLAGS_B;
				FLAGS_B: begin
					flags_q <= rx_byte;
					accum_q <= '0;
					idx_q   <= '0;
					phase_q <= LENGTH_B;
				end
				LENGTH_B: begin
					accum_q <= accum_nx;
					idx_q   <= idx_nx;
					if (rx_byte[7]) begin
						if (too_long) phase_q <= HUNT;
					end else begin
						left_q  <= accum_nx;
						phase_q <= (accum_nx == '0) ? END_B : PAYLOAD_B;
					end
				end
				PAYLOAD_B: begin
					left_q <= left_nx;
					if (left_nx == '0) phase_q <= END_B;
				end
				END_B: phase_q <= HUNT;
				default: phase_q <= HUNT;
			endcase
		end
	end

	always_comb begin
		push                = 1'b0;
		push_entry.kind     = rdvl_pkg::KIND_STATUS;
		push_entry.data     = rx_byte;
		push_entry.rtype    = type_q;
		push_entry.reply    = reply_q;
		push_entry.flags    = flags_q;
		push_entry.length   = accum_q;
		push_entry.status   = rdvl_pkg::ST_OK;
		unique case (phase_q)
			LENGTH_B: begin
				push              = beat && rx_byte[7] && too_long;
				push_entry.length = accum_nx;
				push_entry.status = rdvl_pkg::ST_TOO_LONG;
			end
			PAYLOAD_B: begin
				push            = beat;
				push_entry.kind = rdvl_pkg::KIND_DATA;
			end
			END_B: begin
				push              = beat;
				push_entry.status = (rx_byte == cfg.end_marker) ?
					rdvl_pkg::ST_OK : rdvl_pkg::ST_NO_END;
			end
			default: push = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/rdvl_queue.sv */
// rdvl_queue: short queue of parsed entries between parser and output.
// Depends on rdvl_pkg.
`default_nettype none
module rdvl_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rdvl_pkg::entry_t push_entry,
	input  wire logic             pop,
	output logic                  full,
	output logic                  not_empty,
	output rdvl_pkg::entry_t      head
);

	localparam int unsigned PTR_W = $clog2(rdvl_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(rdvl_pkg::QUEUE_DEPTH + 1);

	rdvl_pkg::entry_t   slot_q [rdvl_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full      = (cnt_q == CNT_W'(rdvl_pkg::QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(rdvl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)  rd_q <= (rd_q == PTR_W'(rdvl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");

endmodule
`default_nettype wire

/* hw/rtl/rdvl_back.sv */
// rdvl_back: output stage; turns queue entries into result beats and
// applies the type remap.
// Depends on rdvl_pkg.
`default_nettype none
module rdvl_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rdvl_pkg::cfg_t   cfg,
	input  wire logic             q_valid,
	input  wire rdvl_pkg::entry_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  kind,
	output logic [7:0]            data_byte,
	output logic [7:0]            record_type,
	output logic [7:0]            mapped_type,
	output logic [7:0]            reply_line,
	output logic [7:0]            flag_bits,
	output logic [rdvl_pkg::LEN_W-1:0] payload_length,
	output logic [1:0]            status,
	output logic                  last
);

	logic valid_q;
	logic is_stat;

	assign out_valid = valid_q;
	assign pop       = q_valid && (!valid_q || !out_stall);
	assign is_stat   = (head.kind == rdvl_pkg::KIND_STATUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind           <= head.kind;
			data_byte      <= is_stat ? 8'd0 : head.data;
			record_type    <= is_stat ? head.rtype : 8'd0;
			mapped_type    <= !is_stat ? 8'd0 :
				(head.rtype > cfg.max_type) ? cfg.fallback_type : head.rtype;
			reply_line     <= is_stat ? head.reply : 8'd0;
			flag_bits      <= is_stat ? head.flags : 8'd0;
			payload_length <= is_stat ? head.length : '0;
			status         <= is_stat ? head.status : rdvl_pkg::ST_OK;
			last           <= is_stat;
		end
	end

	a_last_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == kind))
		else $error("last does not match kind");
	a_status_only_closing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == rdvl_pkg::KIND_DATA) |-> (status == rdvl_pkg::ST_OK))
		else $error("status set on a data beat");

endmodule
`default_nettype wire
